// ----- hw/rtl/htsed_pkg.sv -----
// ----------------------------------------------------------------------------
// htsed_pkg
// Shared types, character codes and the entity name table of the tag
// stripper and entity decoder.
// ----------------------------------------------------------------------------
package htsed_pkg;

	localparam int NUM_NAMES = 37;
	localparam int COPY_IDX  = 36;
	localparam int NAME_MAXLEN = 6;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_CAP_C = 8'h43;

	// names are right-justified in 48 bits
	localparam logic [47:0] NAME_STR [NUM_NAMES] = '{
		"agrave", "aacute", "acirc", "atilde", "auml", "aring", "aelig", "amp",
		"ccedil", "egrave", "eacute", "ecirc", "euml", "eth", "igrave", "iacute",
		"icirc", "iuml", "gt", "lt", "ntilde", "nbsp", "ograve", "oacute",
		"ocirc", "otilde", "ouml", "oslash", "quot", "szlig", "thorn", "ugrave",
		"uacute", "ucirc", "uuml", "yacute", "copy"
	};

	localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
		3'd6, 3'd6, 3'd5, 3'd6, 3'd4, 3'd5, 3'd5, 3'd3,
		3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd6, 3'd6,
		3'd5, 3'd4, 3'd2, 3'd2, 3'd6, 3'd4, 3'd6, 3'd6,
		3'd5, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5, 3'd5, 3'd6,
		3'd6, 3'd5, 3'd4, 3'd6, 3'd4
	};

	localparam logic [7:0] NAME_VAL [NUM_NAMES] = '{
		8'he0, 8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'h26,
		8'he7, 8'he8, 8'he9, 8'hea, 8'heb, 8'hf0, 8'hec, 8'hed,
		8'hee, 8'hef, 8'h3e, 8'h3c, 8'hf1, 8'h20, 8'hf2, 8'hf3,
		8'hf4, 8'hf5, 8'hf6, 8'hf8, 8'h22, 8'hdf, 8'hfe, 8'hf9,
		8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'h00
	};

	// character k of name i; valid for k below the name length
	function automatic logic [7:0] name_char(input int i, input int k);
		int sh;
		sh = (int'(NAME_LEN[i]) - 1 - k) * 8;
		return NAME_STR[i][sh +: 8];
	endfunction

	// fold A-Z to a-z
	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	typedef struct packed {
		logic       start;
		logic       step;
		logic [7:0] ch;
	} dec_ctl_t;

	typedef struct packed {
		logic [7:0] val;
		logic       is_copy;
	} dec_res_t;

endpackage

// ----- hw/rtl/htsed_if.sv -----
// ----------------------------------------------------------------------------
// htsed_in_if / htsed_out_if
// Valid/ready channels for raw text bytes and for stripped output bytes.
// ----------------------------------------------------------------------------
interface htsed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;
	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface htsed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hw/rtl/html_tag_strip_entity_decode.sv -----
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode
// Strips markup tags from a byte stream and decodes character entities.
// ----------------------------------------------------------------------------
// One input byte is taken at a time; ready stays low until that byte's
// results are handed to the output register. A plain byte passes through
// the idle, feed and flush states. A ';' that closes an entity scans the
// buffered name through the shared decoder, latches the decoded value and
// emits a nonzero value in EMIT1, or "(C)" in EMIT1 to EMIT3. An overflowing
// entity replays the buffered bytes through the same parse step, one byte a
// cycle. Output stalls hold the sequencer wherever a byte must be emitted.
module html_tag_strip_entity_decode #(
	parameter int ENTITY_MAX = 9
) (
	input logic         clk,
	input logic         arst_n,
	htsed_in_if.sink    text_in,
	htsed_out_if.source text_out
);

	localparam int LW = $clog2(ENTITY_MAX + 1);
	localparam int IW = $clog2(ENTITY_MAX);

	typedef enum logic [1:0] {M_TEXT, M_TAG, M_ENT} mode_t;
	typedef enum logic [2:0] {
		S_IDLE, S_FEED, S_REPLAY, S_SCAN, S_EMIT1, S_EMIT2, S_EMIT3, S_FLUSH
	} state_t;

	state_t        state_q;
	mode_t         mode_q;
	logic [LW-1:0] len_q, dlen_q, rcnt_q, rp_q, k_q;
	logic [7:0]    buf_q [ENTITY_MAX];
	logic [7:0]    b_q, pend_q, out_byte_q, val_q;
	logic          eot_q, pend_v_q, out_v_q, out_last_q, ret_q, copy_q;

	htsed_pkg::dec_ctl_t dec_ctl;
	htsed_pkg::dec_res_t dec_res;

	logic [7:0] cur_b;
	logic       can_emit, f_emit, f_wr, f_dec, f_ovf, scan_end;
	mode_t      f_mode;

	assign text_in.ready   = (state_q == S_IDLE);
	assign text_out.valid  = out_v_q;
	assign text_out.out_byte = out_byte_q;
	assign text_out.out_last = out_last_q;
	assign can_emit = !pend_v_q || !out_v_q;

	// pick the byte to parse: current byte, or replayed buffer entry
	assign cur_b = (state_q == S_REPLAY && rp_q != rcnt_q) ? buf_q[rp_q[IW-1:0]] : b_q;

	// one parse step on cur_b
	always_comb begin
		f_emit = 1'b0;
		f_wr   = 1'b0;
		f_dec  = 1'b0;
		f_ovf  = 1'b0;
		f_mode = mode_q;
		case (mode_q)
			M_TAG: if (cur_b == htsed_pkg::CH_GT) f_mode = M_TEXT;
			M_ENT: begin
				if (cur_b == htsed_pkg::CH_SEMI) begin
					f_dec = 1'b1;
					f_mode = M_TEXT;
				end else if (len_q < LW'(ENTITY_MAX)) f_wr = 1'b1;
				else begin
					f_ovf = 1'b1;
					f_emit = 1'b1;
					f_mode = M_TEXT;
				end
			end
			default: begin
				if (cur_b == htsed_pkg::CH_AMP) f_mode = M_ENT;
				else if (cur_b == htsed_pkg::CH_LT) f_mode = M_TAG;
				else begin
					f_mode = M_TEXT;
					f_emit = 1'b1;
				end
			end
		endcase
	end

	assign scan_end = (k_q == dlen_q) || (buf_q[k_q[IW-1:0]] == 8'd0);

	// drive the shared decoder
	always_comb begin
		dec_ctl.start = (state_q == S_FEED || state_q == S_REPLAY) && can_emit && f_dec;
		dec_ctl.step  = (state_q == S_SCAN) && !scan_end;
		dec_ctl.ch    = buf_q[k_q[IW-1:0]];
	end

	htsed_decoder #(.LW(LW)) u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dec_ctl),
		.idx    (k_q),
		.res    (dec_res)
	);

	// hold the entity buffer
	always_ff @(posedge clk) begin
		if ((state_q == S_FEED || state_q == S_REPLAY) && can_emit && f_wr)
			buf_q[len_q[IW-1:0]] <= cur_b;
	end

	// sequencer, parse state and output staging
	always_ff @(posedge clk or negedge arst_n) begin
		logic       emit;
		logic [7:0] eb;
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= M_TEXT;
			len_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			out_last_q <= 1'b0;
			out_byte_q <= 8'd0;
			pend_q   <= 8'd0;
			b_q      <= 8'd0;
			eot_q    <= 1'b0;
			dlen_q   <= '0;
			rcnt_q   <= '0;
			rp_q     <= '0;
			k_q      <= '0;
			ret_q    <= 1'b0;
			val_q    <= 8'd0;
			copy_q   <= 1'b0;
		end else begin
			emit = 1'b0;
			eb   = 8'd0;
			if (out_v_q && text_out.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (text_in.valid) begin
						b_q   <= text_in.in_byte;
						eot_q <= text_in.end_of_text;
						state_q <= S_FEED;
					end
				end
				S_FEED, S_REPLAY: begin
					if (can_emit) begin
						mode_q <= f_mode;
						emit = f_emit;
						eb = f_ovf ? htsed_pkg::CH_AMP : cur_b;
						if (f_wr) len_q <= len_q + 1'b1;
						if (cur_b == htsed_pkg::CH_AMP && mode_q == M_TEXT) len_q <= '0;
						if (state_q == S_REPLAY) rp_q <= rp_q + 1'b1;
						if (f_ovf) begin
							rcnt_q <= len_q;
							rp_q   <= '0;
							len_q  <= '0;
							state_q <= S_REPLAY;
						end else if (f_dec) begin
							dlen_q <= len_q;
							len_q  <= '0;
							k_q    <= '0;
							ret_q  <= (state_q == S_REPLAY) && (rp_q != rcnt_q);
							state_q <= S_SCAN;
						end else if (state_q == S_FEED || rp_q == rcnt_q) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						val_q  <= dec_res.val;
						copy_q <= dec_res.is_copy;
						state_q <= S_EMIT1;
					end else k_q <= k_q + 1'b1;
				end
				S_EMIT1: begin
					if (val_q != 8'd0) begin
						if (can_emit) begin
							emit = 1'b1;
							eb = val_q;
							state_q <= ret_q ? S_REPLAY : S_FLUSH;
						end
					end else if (copy_q) begin
						if (can_emit) begin
							emit = 1'b1;
							eb = htsed_pkg::CH_LPAR;
							state_q <= S_EMIT2;
						end
					end else state_q <= ret_q ? S_REPLAY : S_FLUSH;
				end
				S_EMIT2: begin
					if (can_emit) begin
						emit = 1'b1;
						eb = htsed_pkg::CH_CAP_C;
						state_q <= S_EMIT3;
					end
				end
				S_EMIT3: begin
					if (can_emit) begin
						emit = 1'b1;
						eb = htsed_pkg::CH_RPAR;
						state_q <= ret_q ? S_REPLAY : S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || !out_v_q) begin
						if (pend_v_q) begin
							out_v_q    <= 1'b1;
							out_byte_q <= pend_q;
							out_last_q <= 1'b1;
							pend_v_q   <= 1'b0;
						end
						if (eot_q) begin
							mode_q <= M_TEXT;
							len_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// stage the new byte; push the older one out as not last
			if (emit) begin
				if (pend_v_q) begin
					out_v_q    <= 1'b1;
					out_byte_q <= pend_q;
					out_last_q <= 1'b0;
				end
				pend_q   <= eb;
				pend_v_q <= 1'b1;
			end
		end
	end

	// ready only with no staged byte left over
	a_ready_clean: assert property (@(posedge clk) disable iff (!arst_n)
		text_in.ready |-> !pend_v_q)
		else $error("ready raised with a staged byte");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(ENTITY_MAX))
		else $error("entity length beyond buffer");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(text_in.valid && text_in.ready) |=> !text_in.ready)
		else $error("ready held after a transaction");

endmodule

// ----- hw/rtl/htsed_decoder.sv -----
// ----------------------------------------------------------------------------
// htsed_decoder
// Entity name decoder: consumes one buffered name character per step and
// tracks both the table match and a strtol-style numeric parse.
// ----------------------------------------------------------------------------
module htsed_decoder #(
	parameter int LW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  htsed_pkg::dec_ctl_t ctl,
	input  logic [LW-1:0]       idx,
	output htsed_pkg::dec_res_t res
);

	typedef enum logic [2:0] {
		P_HASH, P_WS, P_PFX, P_ZX, P_DIG, P_STOP
	} phase_t;

	logic [htsed_pkg::NUM_NAMES-1:0] mask_q, mask_d;
	logic       num_q, num_d;
	logic       hex_q, hex_d;
	logic       neg_q, neg_d;
	logic [7:0] v_q, v_d;
	phase_t     phase_q, phase_d;

	// advance the numeric parse and the name match by one character
	always_comb begin
		logic [7:0] c;
		logic       ws, dig_ok, go_pfx, go_dig;
		logic [7:0] d;
		c = htsed_pkg::fold(ctl.ch);
		mask_d  = mask_q;
		num_d   = num_q;
		hex_d   = hex_q;
		neg_d   = neg_q;
		v_d     = v_q;
		phase_d = phase_q;
		go_pfx  = 1'b0;
		go_dig  = 1'b0;
		ws = (c == htsed_pkg::CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
		d = 8'd0;
		dig_ok = 1'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			dig_ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			dig_ok = hex_d;
		end
		if (idx == '0) begin
			num_d = (c == htsed_pkg::CH_HASH);
			phase_d = P_HASH;
		end
		for (int i = 0; i < htsed_pkg::NUM_NAMES; i++) begin
			if (int'(idx) >= int'(htsed_pkg::NAME_LEN[i])) begin
				mask_d[i] = 1'b0;
			end else if (htsed_pkg::name_char(i, int'(idx)) != c) begin
				mask_d[i] = 1'b0;
			end
		end
		if (num_q && idx != '0) begin
			case (phase_q)
				P_HASH: begin
					if (c == htsed_pkg::CH_X) begin
						hex_d = 1'b1;
						phase_d = P_WS;
					end else begin
						hex_d = 1'b0;
						dig_ok = (c >= 8'h30 && c <= 8'h39);
						if (ws) phase_d = P_WS;
						else if (c == htsed_pkg::CH_PLUS || c == htsed_pkg::CH_MINUS) begin
							neg_d = (c == htsed_pkg::CH_MINUS);
							phase_d = P_DIG;
						end else go_dig = 1'b1;
					end
				end
				P_WS: begin
					if (ws) phase_d = P_WS;
					else if (c == htsed_pkg::CH_PLUS || c == htsed_pkg::CH_MINUS) begin
						neg_d = (c == htsed_pkg::CH_MINUS);
						phase_d = hex_q ? P_PFX : P_DIG;
					end else if (hex_q) go_pfx = 1'b1;
					else go_dig = 1'b1;
				end
				P_PFX: go_pfx = 1'b1;
				P_ZX: begin
					if (c == htsed_pkg::CH_X) phase_d = P_DIG;
					else go_dig = 1'b1;
				end
				P_DIG: go_dig = 1'b1;
				default: phase_d = P_STOP;
			endcase
			if (go_pfx) begin
				if (c == htsed_pkg::CH_ZERO) phase_d = P_ZX;
				else go_dig = 1'b1;
			end
			if (go_dig) begin
				if (dig_ok) begin
					v_d = hex_d ? {v_q[3:0], d[3:0]} : ({v_q[4:0], 3'b000} + {v_q[6:0], 1'b0} + d);
					phase_d = P_DIG;
				end else phase_d = P_STOP;
			end
		end
	end

	// hold parse state; clear on start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '1;
			num_q   <= 1'b0;
			hex_q   <= 1'b0;
			neg_q   <= 1'b0;
			v_q     <= 8'd0;
			phase_q <= P_HASH;
		end else if (ctl.start) begin
			mask_q  <= '1;
			num_q   <= 1'b0;
			hex_q   <= 1'b0;
			neg_q   <= 1'b0;
			v_q     <= 8'd0;
			phase_q <= P_HASH;
		end else if (ctl.step) begin
			mask_q  <= mask_d;
			num_q   <= num_d;
			hex_q   <= hex_d;
			neg_q   <= neg_d;
			v_q     <= v_d;
			phase_q <= phase_d;
		end
	end

	// select the matched value for the name length reached
	always_comb begin
		logic [7:0] nv;
		nv = 8'd0;
		for (int i = 0; i < htsed_pkg::NUM_NAMES; i++) begin
			if (mask_q[i] && int'(idx) == int'(htsed_pkg::NAME_LEN[i])) nv |= htsed_pkg::NAME_VAL[i];
		end
		res.val = num_q ? (neg_q ? 8'd0 - v_q : v_q) : nv;
		res.is_copy = !num_q && mask_q[htsed_pkg::COPY_IDX] && (int'(idx) == 4);
	end

endmodule

// ----- sim/htsed_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htsed_checker
// Watches the text and output channels of the tag stripper, predicts the
// output bytes of every accepted text byte and compares them in order.
// ----------------------------------------------------------------------------
module htsed_checker #(
	parameter int ENTITY_MAX = 9
) (
	input  logic clk,
	input  logic arst_n,
	htsed_in_if  text_in,
	htsed_out_if text_out,
	output int   fail_count,
	output int   pending,
	output int   byte_count
);

	typedef enum logic [1:0] {PM_TEXT = 2'd0, PM_TAG = 2'd1, PM_ENT = 2'd2} parse_mode_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	out_byte_t   out_expect_q[$];
	parse_mode_t mode;
	logic [7:0]  name_buf [ENTITY_MAX];
	int          name_len;

	assign pending = out_expect_q.size();

	// queue one output byte of the current transaction
	function automatic void push_out(logic [7:0] b);
		out_byte_t e;
		e.data = b;
		e.last = 1'b0;
		out_expect_q.push_back(e);
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == htsed_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	// read a number as strtol would, keeping only the low eight bits
	function automatic logic [7:0] read_number(logic [7:0] nm [ENTITY_MAX], int len,
		int pos, int base);
		logic [7:0] v;
		bit neg;
		int d;
		v = 8'd0;
		neg = 1'b0;
		while (pos < len && is_space(nm[pos])) pos++;
		if (pos < len && (nm[pos] == htsed_pkg::CH_PLUS || nm[pos] == htsed_pkg::CH_MINUS)) begin
			neg = (nm[pos] == htsed_pkg::CH_MINUS);
			pos++;
		end
		if (base == 16 && pos + 1 < len && nm[pos] == htsed_pkg::CH_ZERO &&
			nm[pos + 1] == htsed_pkg::CH_X)
			pos += 2;
		while (pos < len) begin
			if (nm[pos] >= "0" && nm[pos] <= "9") d = nm[pos] - "0";
			else if (nm[pos] >= "a" && nm[pos] <= "f") d = nm[pos] - "a" + 10;
			else d = -1;
			if (d < 0 || d >= base) break;
			v = 8'(int'(v) * base + d);
			pos++;
		end
		return neg ? 8'd0 - v : v;
	endfunction

	// decode the buffered entity name into zero, one or three bytes
	function automatic void decode_entity();
		logic [7:0] nm [ENTITY_MAX];
		logic [7:0] val;
		int len;
		bit hit;
		len = 0;
		val = 8'd0;
		while (len < name_len && name_buf[len] != 8'd0) begin
			nm[len] = fold_case(name_buf[len]);
			len++;
		end
		if (len == 0) return;
		if (nm[0] == htsed_pkg::CH_HASH) begin
			if (len >= 2 && nm[1] == htsed_pkg::CH_X) val = read_number(nm, len, 2, 16);
			else val = read_number(nm, len, 1, 10);
		end else begin
			for (int i = 0; i < htsed_pkg::NUM_NAMES; i++) begin
				if (int'(htsed_pkg::NAME_LEN[i]) == len) begin
					hit = 1'b1;
					for (int k = 0; k < len; k++)
						if (htsed_pkg::NAME_STR[i][(len - 1 - k) * 8 +: 8] != nm[k])
							hit = 1'b0;
					if (hit) begin
						val = htsed_pkg::NAME_VAL[i];
						break;
					end
				end
			end
		end
		if (val != 8'd0) begin
			push_out(val);
		end else if (len == 4 && nm[0] == "c" && nm[1] == "o" && nm[2] == "p" &&
			nm[3] == "y") begin
			push_out(htsed_pkg::CH_LPAR);
			push_out(htsed_pkg::CH_CAP_C);
			push_out(htsed_pkg::CH_RPAR);
		end
	endfunction

	// advance the parser by one byte; return 1 on entity overflow
	function automatic bit parse_byte(logic [7:0] b);
		case (mode)
			PM_TAG: begin
				if (b == htsed_pkg::CH_GT) mode = PM_TEXT;
			end
			PM_ENT: begin
				if (b == htsed_pkg::CH_SEMI) begin
					decode_entity();
					mode = PM_TEXT;
					name_len = 0;
				end else if (name_len < ENTITY_MAX) begin
					name_buf[name_len] = b;
					name_len++;
				end else begin
					return 1'b1;
				end
			end
			default: begin
				if (b == htsed_pkg::CH_AMP) begin
					mode = PM_ENT;
					name_len = 0;
				end else if (b == htsed_pkg::CH_LT) begin
					mode = PM_TAG;
				end else begin
					push_out(b);
				end
			end
		endcase
		return 1'b0;
	endfunction

	// predict all output bytes of one text transaction
	function automatic void predict_text(logic [7:0] b, logic eot);
		logic [7:0] replay [ENTITY_MAX + 1];
		int cnt;
		int first;
		bit unused;
		first = out_expect_q.size();
		if (parse_byte(b)) begin
			cnt = name_len;
			for (int i = 0; i < cnt; i++) replay[i] = name_buf[i];
			replay[cnt] = b;
			push_out(htsed_pkg::CH_AMP);
			mode = PM_TEXT;
			name_len = 0;
			for (int i = 0; i <= cnt; i++) unused = parse_byte(replay[i]);
		end
		if (eot) begin
			mode = PM_TEXT;
			name_len = 0;
		end
		if (out_expect_q.size() > first) out_expect_q[$].last = 1'b1;
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = PM_TEXT;
			name_len = 0;
			fail_count <= 0;
			byte_count <= 0;
			out_expect_q.delete();
		end else begin
			if (text_in.valid && text_in.ready)
				predict_text(text_in.in_byte, text_in.end_of_text);
			if (text_out.valid && text_out.ready) begin
				byte_count <= byte_count + 1;
				if (out_expect_q.size() == 0) begin
					$display("%0t: unexpected output byte %h last %b", $time,
						text_out.out_byte, text_out.out_last);
					fail_count <= fail_count + 1;
				end else begin
					if (text_out.out_byte !== out_expect_q[0].data ||
						text_out.out_last !== out_expect_q[0].last) begin
						$display("%0t: mismatch expected byte %h last %b, got byte %h last %b",
							$time, out_expect_q[0].data, out_expect_q[0].last,
							text_out.out_byte, text_out.out_last);
						fail_count <= fail_count + 1;
					end
					void'(out_expect_q.pop_front());
				end
			end
		end
	end

endmodule

// ----- sim/tb_html_tag_strip_entity_decode.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_html_tag_strip_entity_decode
// Drives directed and random text through the tag stripper with bursty
// input and a stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_html_tag_strip_entity_decode;

	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [7:0] data;
		logic       eot;
	} text_item_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   byte_count;
	int   idle_cycles;
	int   sent;
	text_item_t text_q[$];

	htsed_in_if  text_in ();
	htsed_out_if text_out ();

	html_tag_strip_entity_decode dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.text_out (text_out)
	);

	htsed_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.text_out   (text_out),
		.fail_count (fail_count),
		.pending    (pending),
		.byte_count (byte_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// queue text items
	function automatic void add_byte(logic [7:0] b, logic eot = 1'b0);
		text_item_t t;
		t.data = b;
		t.eot = eot;
		text_q.push_back(t);
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	// random letter, upper or lower case
	function automatic logic [7:0] rand_case(logic [7:0] c);
		return ($urandom_range(0, 1) && c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// one random well-formed or broken fragment of text
	function automatic void add_fragment();
		int kind;
		int n;
		int idx;
		string digits;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
			end
			2: begin
				add_byte(htsed_pkg::CH_LT);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
				add_byte(htsed_pkg::CH_GT);
			end
			3, 4: begin
				idx = $urandom_range(0, htsed_pkg::NUM_NAMES - 1);
				add_byte(htsed_pkg::CH_AMP);
				for (int k = 0; k < int'(htsed_pkg::NAME_LEN[idx]); k++)
					add_byte(rand_case(htsed_pkg::NAME_STR[idx][
						(int'(htsed_pkg::NAME_LEN[idx]) - 1 - k) * 8 +: 8]));
				add_byte(htsed_pkg::CH_SEMI);
			end
			5: begin
				add_str("&#");
				if ($urandom_range(0, 3) == 0) add_byte(htsed_pkg::CH_MINUS);
				add_str($sformatf("%0d;", $urandom_range(0, 999)));
			end
			6: begin
				add_str($urandom_range(0, 1) ? "&#x" : "&#X");
				if ($urandom_range(0, 3) == 0) add_str("0x");
				digits = $sformatf("%0h;", $urandom_range(0, 4095));
				add_str(digits);
			end
			7: begin
				add_byte(htsed_pkg::CH_AMP);
				n = $urandom_range(8, 11);
				for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
			end
			8: begin
				add_byte(htsed_pkg::CH_AMP);
				n = $urandom_range(0, 9);
				for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
				add_byte(htsed_pkg::CH_SEMI);
			end
			default: begin
				add_byte(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endfunction

	// output stall pattern: stretches of no stall, of light stall and of heavy stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_out.ready <= 1'b0;
		end else begin
			case ((sent / 40) % 3)
				0: text_out.ready <= 1'b1;
				1: text_out.ready <= ($urandom_range(0, 3) != 0);
				default: text_out.ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// watchdog on transaction activity
	always @(posedge clk) begin
		if (!arst_n || (text_in.valid && text_in.ready) ||
			(text_out.valid && text_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("html_tag_strip_entity_decode test failed");
			$finish;
		end
	end

	initial begin
		int gap;
		int burst;
		text_item_t t;
		arst_n = 1'b0;
		sent = 0;
		text_in.valid = 1'b0;
		text_in.in_byte = 8'd0;
		text_in.end_of_text = 1'b0;

		// directed text: extremes, tags, names, numbers, unknown, overflow, zero byte
		add_byte(8'h00);
		add_byte(8'hff);
		add_str("<b>&AmP;&copy;&#65;&#x4a;&#-1;&#x0x7e;&;&zz;&ab");
		add_byte(8'h00);
		add_str("c;&abcdefghij");
		add_str("&lt");
		add_byte("x", 1'b1);
		add_str("&# 9;&Thorn;&nbsp;");

		for (int i = 0; i < 44; i++) add_fragment();
		add_byte("!", 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bursts of transactions with random gaps
		burst = 0;
		while (text_q.size() > 0) begin
			if (sent == 150) begin
				text_in.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					text_in.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 12);
			end
			t = text_q.pop_front();
			text_in.valid <= 1'b1;
			text_in.in_byte <= t.data;
			text_in.end_of_text <= t.eot;
			@(posedge clk);
			while (!text_in.ready) @(posedge clk);
			sent++;
			burst--;
		end
		text_in.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d text bytes: tags, named and numeric entities, overflow,",
			sent);
		$display("end of text and raw bytes; checked %0d output bytes.", byte_count);
		if (fail_count == 0)
			$display("html_tag_strip_entity_decode test passed");
		else
			$display("html_tag_strip_entity_decode test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/htsed_pkg.sv
hw/rtl/htsed_if.sv
hw/rtl/htsed_decoder.sv
hw/rtl/html_tag_strip_entity_decode.sv
sim/htsed_checker.sv
sim/tb_html_tag_strip_entity_decode.sv
